/* sv/bgs_pkg.sv */
// shared types, constants and arithmetic helpers for the burgers godunov step block
`default_nettype none
package bgs_pkg;

    // payload and register widths
    localparam int DATA_W        = 16;
    localparam int CFG_W         = 16;
    localparam int GRID_CELLS    = 128;
    localparam int POS_W         = $clog2(GRID_CELLS);
    localparam int SQ_W          = 2 * DATA_W - 1;
    localparam int DIFF_W        = SQ_W + 1;
    localparam int PROD_W        = DIFF_W + CFG_W;
    localparam int ACC_W         = PROD_W + 1;
    localparam int FRAC_SHIFT    = 27;
    localparam int Q_W           = ACC_W - FRAC_SHIFT;
    localparam logic [CFG_W-1:0] COURANT_RESET = CFG_W'(16384);

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_FLUX,
        ST_MULT,
        ST_RESULT,
        ST_EMIT_PREV,
        ST_EMIT_LAST
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic square;
        logic flux;
        logic mult;
        logic result;
        logic out_valid;
        logic out_last;
    } t_dp_cmd;

    // status from datapath to controller, captured when an item is taken
    typedef struct packed {
        logic has_prev;
        logic last;
    } t_dp_status;

    // exact riemann flux for f = u*u/2, in units of 2^-21 (squares given)
    function automatic logic [SQ_W-1:0] riemann_flux(
        input logic signed [DATA_W-1:0] ul,
        input logic signed [DATA_W-1:0] ur,
        input logic [SQ_W-1:0]          fl,
        input logic [SQ_W-1:0]          fr
    );
        logic [SQ_W-1:0] f;
        if (ul >= ur) begin
            f = (fl > fr) ? fl : fr;
        end else if (ul <= 0 && ur >= 0) begin
            f = '0;
        end else begin
            f = (fl < fr) ? fl : fr;
        end
        return f;
    endfunction

    // clamp a wide signed value to the data range
    function automatic logic signed [DATA_W-1:0] saturate(
        input logic signed [Q_W-1:0] q
    );
        logic signed [DATA_W-1:0] r;
        if (&q[Q_W-1:DATA_W-1] || ~|q[Q_W-1:DATA_W-1]) begin
            r = q[DATA_W-1:0];
        end else if (q[Q_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/bgs_ifs.sv */
// valid/ready channel interfaces for cell items in and updated cell items out
`default_nettype none
interface bgs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bgs_pkg::DATA_W-1:0]    cell_value;
    logic                                 last_cell;

    modport source (output valid, output cell_value, output last_cell, input ready);
    modport sink   (input valid, input cell_value, input last_cell, output ready);
endinterface

interface bgs_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bgs_pkg::DATA_W-1:0]    new_value;
    logic                                 last_out;

    modport source (output valid, output new_value, output last_out, input ready);
    modport sink   (input valid, input new_value, input last_out, output ready);
endinterface
`default_nettype wire

/* sv/bgs_ctrl.sv */
// controller state machine sequencing square, flux, multiply, result and emit steps
`default_nettype none
module bgs_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_out_ready,
    input  wire bgs_pkg::t_dp_status i_status,
    output bgs_pkg::t_dp_cmd         o_cmd
);

    bgs_pkg::t_state r_state;
    bgs_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bgs_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = bgs_pkg::ST_SQUARE;
            end
            bgs_pkg::ST_SQUARE: n_state = bgs_pkg::ST_FLUX;
            bgs_pkg::ST_FLUX:   n_state = bgs_pkg::ST_MULT;
            bgs_pkg::ST_MULT:   n_state = bgs_pkg::ST_RESULT;
            bgs_pkg::ST_RESULT: begin
                priority if (i_status.has_prev) n_state = bgs_pkg::ST_EMIT_PREV;
                else if (i_status.last)         n_state = bgs_pkg::ST_EMIT_LAST;
                else                            n_state = bgs_pkg::ST_IDLE;
            end
            bgs_pkg::ST_EMIT_PREV: begin
                if (i_out_ready) begin
                    n_state = i_status.last ? bgs_pkg::ST_EMIT_LAST : bgs_pkg::ST_IDLE;
                end
            end
            bgs_pkg::ST_EMIT_LAST: begin
                if (i_out_ready) n_state = bgs_pkg::ST_IDLE;
            end
            default: n_state = bgs_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bgs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bgs_pkg::ST_SQUARE: o_cmd.square = 1'b1;
            bgs_pkg::ST_FLUX:   o_cmd.flux   = 1'b1;
            bgs_pkg::ST_MULT:   o_cmd.mult   = 1'b1;
            bgs_pkg::ST_RESULT: o_cmd.result = 1'b1;
            bgs_pkg::ST_EMIT_PREV: o_cmd.out_valid = 1'b1;
            bgs_pkg::ST_EMIT_LAST: begin
                o_cmd.out_valid = 1'b1;
                o_cmd.out_last  = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* sv/bgs_datapath.sv */
// datapath: cell window, squares, flux difference, courant product and rounding
`default_nettype none
module bgs_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bgs_pkg::t_dp_cmd                  i_cmd,
    output bgs_pkg::t_dp_status                    o_status,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [bgs_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  wire logic signed [bgs_pkg::DATA_W-1:0] i_cell_value,
    input  wire logic                              i_last_cell,
    output logic signed [bgs_pkg::DATA_W-1:0]      o_new_value,
    output logic                                   o_last_out
);

    logic [bgs_pkg::CFG_W-1:0]         r_courant;
    logic signed [bgs_pkg::DATA_W-1:0] r_win0, r_win1, r_u, r_res;
    logic [bgs_pkg::SQ_W-1:0]          r_sq0, r_sq1, r_sq_u;
    logic [bgs_pkg::POS_W-1:0]         r_pos;
    logic                              r_has_prev, r_last, r_pass;
    logic signed [bgs_pkg::DIFF_W-1:0] r_diff;
    logic signed [bgs_pkg::PROD_W-1:0] r_prod;

    logic signed [2*bgs_pkg::DATA_W-1:0] w_sq;
    logic [bgs_pkg::SQ_W-1:0]            w_f_right, w_f_left;
    logic signed [bgs_pkg::PROD_W-1:0]   w_prod;
    logic signed [bgs_pkg::ACC_W-1:0]    w_acc;
    logic                                w_pos_end;

    // courant ratio register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_courant <= bgs_pkg::COURANT_RESET;
        end else if (i_cfg_wr_en) begin
            r_courant <= i_cfg_wr_data;
        end
    end

    // take an item and note where it sits in the grid
    assign w_pos_end = (r_pos == bgs_pkg::POS_W'(bgs_pkg::GRID_CELLS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_prev <= 1'b0;
            r_last     <= 1'b0;
            r_pass     <= 1'b0;
        end else if (i_cmd.load) begin
            r_has_prev <= (r_pos != '0);
            r_last     <= i_last_cell || w_pos_end;
            r_pass     <= (r_pos == bgs_pkg::POS_W'(1)) || (r_pos == bgs_pkg::POS_W'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_u <= i_cell_value;
    end

    // square of the new cell, one multiplier
    assign w_sq = (2*bgs_pkg::DATA_W)'(r_u) * (2*bgs_pkg::DATA_W)'(r_u);

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) r_sq_u <= w_sq[bgs_pkg::SQ_W-1:0];
    end

    // godunov fluxes at both faces of the center cell
    assign w_f_right = bgs_pkg::riemann_flux(r_win1, r_u, r_sq1, r_sq_u);
    assign w_f_left  = bgs_pkg::riemann_flux(r_win0, r_win1, r_sq0, r_sq1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.flux) begin
            r_diff <= $signed({1'b0, w_f_right}) - $signed({1'b0, w_f_left});
        end
    end

    // flux difference times courant ratio
    assign w_prod = bgs_pkg::PROD_W'(r_diff)
                  * bgs_pkg::PROD_W'($signed({1'b0, r_courant}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) r_prod <= w_prod;
    end

    // u*2^27 - product, round half up at 2^-10, saturate
    assign w_acc = (bgs_pkg::ACC_W'(r_win1) <<< bgs_pkg::FRAC_SHIFT)
                 - bgs_pkg::ACC_W'(r_prod)
                 + (bgs_pkg::ACC_W'(1) <<< (bgs_pkg::FRAC_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_res <= r_pass ? r_win1
                            : bgs_pkg::saturate(w_acc[bgs_pkg::ACC_W-1:bgs_pkg::FRAC_SHIFT]);
        end
    end

    // window, its squares and the position advance once the result is formed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
            r_sq0  <= '0;
            r_sq1  <= '0;
            r_pos  <= '0;
        end else if (i_cmd.result) begin
            r_win0 <= r_win1;
            r_win1 <= r_u;
            r_sq0  <= r_sq1;
            r_sq1  <= r_sq_u;
            r_pos  <= r_last ? '0 : r_pos + bgs_pkg::POS_W'(1);
        end
    end

    // result select: previous cell, or the last cell passed through
    assign o_new_value = i_cmd.out_last ? r_u : r_res;
    assign o_last_out  = i_cmd.out_last;

    assign o_status.has_prev = r_has_prev;
    assign o_status.last     = r_last;

endmodule
`default_nettype wire

/* sv/burgers_godunov_stencil_step.sv */
// One cell item in at a time; the result for the previous cell follows the square, flux, multiply and result steps.
// An item gives no result (first cell), one, or two (last cell); it passes the single squarer, flux,
// multiply and rounding steps, and each result is held on the output until it is taken.
// Input is ready only while the controller is idle; output waits on ready without loss.
// Synchronous active-low reset clears the window, position and state, courant ratio to 0.25.
`default_nettype none
module burgers_godunov_stencil_step (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [bgs_pkg::CFG_W-1:0]  i_cfg_wr_data,
    bgs_in_if.sink                          i_in,
    bgs_out_if.source                       o_out
);

    bgs_pkg::t_dp_cmd    w_cmd;
    bgs_pkg::t_dp_status w_status;

    // sequencing
    bgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic and window
    bgs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cell_value  (i_in.cell_value),
        .i_last_cell   (i_in.last_cell),
        .o_new_value   (o_out.new_value),
        .o_last_out    (o_out.last_out)
    );

    assign o_out.valid = w_cmd.out_valid;

endmodule
`default_nettype wire

/* sv/bgs_checker.sv */
// port-level assertions for the burgers godunov step block, bound to the top level
`default_nettype none
module bgs_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [bgs_pkg::DATA_W-1:0] i_new_value,
    input wire logic                              i_last_out
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_new_value)
                                        && $stable(i_last_out))
        else $error("stalled result changed");

    // no item is taken while a result is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result pending");

    // no result is offered right after an item is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result right after accept");

    // the last cell's result ends the item's output
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_out |=> !i_out_valid)
        else $error("result after last cell");

endmodule

bind burgers_godunov_stencil_step bgs_checker u_bgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_new_value (o_out.new_value),
    .i_last_out  (o_out.last_out)
);
`default_nettype wire

/* tb/tb_burgers_godunov_stencil_step.sv */
// self-checking testbench for the burgers godunov stencil step block
`default_nettype none
module tb_burgers_godunov_stencil_step;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_CELLS    = 140;
    localparam int N_DIR          = 22;
    localparam int N_RATIOS       = 7;
    localparam int HOLD_PHASE     = 2;

    // one updated cell as it leaves the block
    typedef struct packed {
        logic signed [bgs_pkg::DATA_W-1:0] value;
        logic                              last;
    } t_cell_out;

    // directed row: input cell plus, where obvious, the results typed in
    typedef struct {
        logic signed [bgs_pkg::DATA_W-1:0] value;
        bit                                last;
        bit                                typed;
        int                                n;
        logic signed [bgs_pkg::DATA_W-1:0] v0;
        bit                                l0;
        logic signed [bgs_pkg::DATA_W-1:0] v1;
        bit                                l1;
    } t_dir_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [bgs_pkg::CFG_W-1:0] i_cfg_wr_data;

    bgs_in_if  cell_in();
    bgs_out_if cell_out();

    burgers_godunov_stencil_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (cell_in),
        .o_out         (cell_out)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predictor state
    logic [bgs_pkg::CFG_W-1:0]         courant = bgs_pkg::COURANT_RESET;
    logic signed [bgs_pkg::DATA_W-1:0] win_prev2 = '0;
    logic signed [bgs_pkg::DATA_W-1:0] win_prev1 = '0;
    int                                grid_pos = 0;
    t_cell_out                         expected_cells[$];

    int  err_count     = 0;
    int  cells_sent    = 0;
    int  cells_checked = 0;
    int  grids_closed  = 0;
    int  ratio_writes  = 0;
    int  burst_left    = 0;
    int  cycle_count   = 0;
    bit  hold_req      = 1'b0;

    // directed stimulus, courant ratio at its reset value of 0.25
    t_dir_row dir_rows [N_DIR] = '{
        // single-cell grids at both extremes
        '{16'sh7FFF,    1, 1, 1, 16'sh7FFF,    1, 16'sd0, 0},
        '{16'sh8000,    1, 1, 1, 16'sh8000,    1, 16'sd0, 0},
        // grid of two, all pass through
        '{16'sd1024,    0, 1, 0, 16'sd0,       0, 16'sd0, 0},
        '{-16'sd1024,   1, 1, 2, 16'sd1024,    0, -16'sd1024, 1},
        // grid of three, all pass through
        '{16'sd5,       0, 1, 0, 16'sd0,       0, 16'sd0, 0},
        '{-16'sd7,      0, 1, 1, 16'sd5,       0, 16'sd0, 0},
        '{16'sd300,     1, 1, 2, -16'sd7,      0, 16'sd300, 1},
        // longer grid: rarefactions, transonic, shock, saturation
        '{16'sd2048,    0, 1, 0, 16'sd0,       0, 16'sd0, 0},
        '{-16'sd2048,   0, 1, 1, 16'sd2048,    0, 16'sd0, 0},
        '{-16'sd1024,   0, 1, 1, -16'sd2048,   0, 16'sd0, 0},
        '{16'sd1024,    0, 0, 0, 16'sd0,       0, 16'sd0, 0},
        '{16'sd2048,    0, 0, 0, 16'sd0,       0, 16'sd0, 0},
        '{16'sd512,     0, 0, 0, 16'sd0,       0, 16'sd0, 0},
        '{16'sh7FFF,    0, 0, 0, 16'sd0,       0, 16'sd0, 0},
        '{16'sh8000,    0, 0, 0, 16'sd0,       0, 16'sd0, 0},
        '{16'sh7FFF,    0, 0, 0, 16'sd0,       0, 16'sd0, 0},
        '{16'sd0,       1, 0, 0, 16'sd0,       0, 16'sd0, 0},
        // tiny values around zero
        '{-16'sd1,      0, 1, 0, 16'sd0,       0, 16'sd0, 0},
        '{16'sd1,       0, 1, 1, -16'sd1,      0, 16'sd0, 0},
        '{-16'sd1,      0, 1, 1, 16'sd1,       0, 16'sd0, 0},
        '{16'sd1,       0, 0, 0, 16'sd0,       0, 16'sd0, 0},
        '{16'sd0,       1, 0, 0, 16'sd0,       0, 16'sd0, 0}
    };

    // exact riemann flux of u*u/2, units of 2^-21
    function automatic longint interface_flux(longint ul, longint ur);
        longint fl;
        longint fr;
        fl = ul * ul;
        fr = ur * ur;
        if (ul >= ur) begin
            return (fl > fr) ? fl : fr;
        end
        if (ul <= 0 && ur >= 0) begin
            return 0;
        end
        return (fl < fr) ? fl : fr;
    endfunction

    // interior update u - c*(F right - F left), rounded and saturated
    function automatic logic signed [bgs_pkg::DATA_W-1:0] godunov_update(longint um,
                                                                         longint u0,
                                                                         longint up);
        longint diff;
        longint acc;
        longint q;
        longint c;
        c    = courant;
        diff = interface_flux(u0, up) - interface_flux(um, u0);
        acc  = u0 * (longint'(1) << 27) - diff * c;
        q    = (acc + (longint'(1) << 26)) >>> 27;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[bgs_pkg::DATA_W-1:0];
    endfunction

    // advance the grid window by one cell, queue the updated cells it releases
    function automatic void predict_cell(logic signed [bgs_pkg::DATA_W-1:0] u, bit lst,
                                         bit keep);
        t_cell_out r;
        bit        fin;
        fin = lst || (grid_pos >= bgs_pkg::GRID_CELLS - 1);
        if (grid_pos >= 1) begin
            r.last = 1'b0;
            if (grid_pos <= 2) begin
                r.value = win_prev1;
            end else begin
                r.value = godunov_update(win_prev2, win_prev1, u);
            end
            if (keep) begin
                expected_cells.push_back(r);
            end
        end
        if (fin) begin
            r.value = u;
            r.last  = 1'b1;
            if (keep) begin
                expected_cells.push_back(r);
            end
            grid_pos = 0;
            grids_closed++;
        end else begin
            grid_pos++;
        end
        win_prev2 = win_prev1;
        win_prev1 = u;
    endfunction

    // offer one cell item, then maybe idle between bursts
    task automatic send_cell(logic signed [bgs_pkg::DATA_W-1:0] u, bit lst, bit keep);
        int gap;
        cell_in.valid      <= 1'b1;
        cell_in.cell_value <= u;
        cell_in.last_cell  <= lst;
        do @(posedge i_clk); while (!cell_in.ready);
        predict_cell(u, lst, keep);
        cells_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            cell_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // stop offering and wait for every queued updated cell
    task automatic wait_all_results();
        cell_in.valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // courant ratio write, block idle
    task automatic write_ratio(logic [bgs_pkg::CFG_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        courant = v;
        ratio_writes++;
    endtask

    // random cell value: full range, extremes, or the physically busy region
    function automatic logic signed [bgs_pkg::DATA_W-1:0] random_cell();
        logic signed [bgs_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: begin
                v = bgs_pkg::DATA_W'($urandom);
            end
            2: begin
                case ($urandom_range(0, 6))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = 16'sd0;
                    3: v = 16'sd1;
                    4: v = -16'sd1;
                    5: v = 16'sd1024;
                    default: v = -16'sd1024;
                endcase
            end
            default: begin
                v = bgs_pkg::DATA_W'(int'($urandom_range(0, 8191)) - 4096);
            end
        endcase
        return v;
    endfunction

    // one grid of random length; a long one may run past the forced last cell
    task automatic send_grid();
        int                                len;
        int                                style;
        int                                walk;
        logic signed [bgs_pkg::DATA_W-1:0] u;
        case ($urandom_range(0, 39))
            0:       len = $urandom_range(120, 170);
            1, 2, 3: len = $urandom_range(1, 3);
            default: len = $urandom_range(4, 24);
        endcase
        style = $urandom_range(0, 2);
        walk  = int'($urandom_range(0, 8191)) - 4096;
        for (int i = 0; i < len; i++) begin
            if (style == 0) begin
                u = random_cell();
            end else begin
                // smooth profile
                walk = walk + int'($urandom_range(0, 1024)) - 512;
                if (walk > 32767) begin
                    walk = 32767;
                end else if (walk < -32768) begin
                    walk = -32768;
                end
                u = bgs_pkg::DATA_W'(walk);
            end
            send_cell(u, i == len - 1, 1'b1);
        end
    endtask

    // receiver: stall patterns in segments, one long hold on request
    initial begin
        int  mode;
        int  seg_len;
        int  rx_tick;
        bit  hold_served;
        cell_out.ready <= 1'b0;
        rx_tick     = 0;
        hold_served = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 80);
            repeat (seg_len) begin
                @(posedge i_clk);
                rx_tick++;
                if (hold_req && !hold_served) begin
                    hold_served = 1'b1;
                    cell_out.ready <= 1'b0;
                    repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0:       cell_out.ready <= 1'b1;
                    1:       cell_out.ready <= rx_tick[0];
                    2:       cell_out.ready <= (rx_tick[1:0] == 2'd0);
                    default: cell_out.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // compare each accepted updated cell with the oldest prediction
    always @(posedge i_clk) begin
        t_cell_out want;
        if (i_rst_n && cell_out.valid && cell_out.ready) begin
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected item value=%0d last=%0d", $time,
                         cell_out.new_value, cell_out.last_out);
                err_count++;
            end else begin
                want = expected_cells.pop_front();
                cells_checked++;
                if (cell_out.new_value !== want.value) begin
                    $display("%0t: new_value expected %0d actual %0d", $time,
                             want.value, cell_out.new_value);
                    err_count++;
                end
                if (cell_out.last_out !== want.last) begin
                    $display("%0t: last_out expected %0d actual %0d", $time,
                             want.last, cell_out.last_out);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d items still expected", $time, expected_cells.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // main sequence
    initial begin
        logic [bgs_pkg::CFG_W-1:0] ratio_plan [N_RATIOS];
        int                        phase_start;
        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_wr_data      <= '0;
        cell_in.valid      <= 1'b0;
        cell_in.cell_value <= '0;
        cell_in.last_cell  <= 1'b0;
        burst_left = $urandom_range(0, 20);
        ratio_plan = '{16'h0000, 16'hFFFF, bgs_pkg::CFG_W'($urandom), 16'h8000,
                       bgs_pkg::CFG_W'($urandom), 16'h0001, bgs_pkg::COURANT_RESET};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].typed && dir_rows[k].n >= 1) begin
                expected_cells.push_back(t_cell_out'{dir_rows[k].v0, dir_rows[k].l0});
            end
            if (dir_rows[k].typed && dir_rows[k].n >= 2) begin
                expected_cells.push_back(t_cell_out'{dir_rows[k].v1, dir_rows[k].l1});
            end
            send_cell(dir_rows[k].value, dir_rows[k].last, !dir_rows[k].typed);
        end
        wait_all_results();

        // random grids, one courant setting per phase
        for (int ph = 0; ph < N_RATIOS; ph++) begin
            write_ratio(ratio_plan[ph]);
            if (ph == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            phase_start = cells_sent;
            while (cells_sent - phase_start < PHASE_CELLS) begin
                send_grid();
            end
            wait_all_results();
        end

        $display("covered %0d cells in %0d grids, %0d updated cells checked",
                 cells_sent, grids_closed, cells_checked);
        $display("courant ratio: reset value and %0d writes incl. 0 and 0xffff", ratio_writes);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
